@@ src/assert_macros.svh @@
// Assertion macros shared by the row resampler RTL.
// Included by any module that carries concurrent checks; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

@@ src/rrrm_pkg.sv @@
// Shared types and constants of the row resampler.
// Used by the sequencer, datapath, output buffer and top level; no dependencies.
`default_nettype none

package rrrm_pkg;

  localparam int unsigned LVL_W      = 8;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned PTS_W      = 13;
  localparam int unsigned INC_W      = 19;
  localparam int unsigned ACC_W      = 20;
  localparam int unsigned REPS_W     = 7;
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned STEP_ONE   = 262144;
  localparam int unsigned MAX_EXPAND = 63;
  localparam int unsigned SLOT_LIMIT = 8191;

  localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(STEP_ONE);

  typedef struct packed {
    logic signed [LVL_W-1:0] level;
    logic                    row_end;
  } in_item_t;

  typedef struct packed {
    logic [LVL_W-1:0] pixel_color;
    logic [IDX_W-1:0] pixel_index;
    logic             last_of_run;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_POINTS  = 2'd0,
    CFG_OUT_POINTS = 2'd1,
    CFG_STEP_INC   = 2'd2,
    CFG_COLOR_OFS  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PTS_W-1:0] in_points;
    logic [PTS_W-1:0] out_points;
    logic [INC_W-1:0] step_inc;
    logic [LVL_W-1:0] color_ofs;
  } cfg_t;

  // Microprogram addresses.
  typedef enum logic [STEP_W-1:0] {
    ST_FETCH     = 4'd0,
    ST_CMP_ACC   = 4'd1,
    ST_CMP_TEST  = 4'd2,
    ST_CMP_EMIT  = 4'd3,
    ST_CMP_TAIL  = 4'd4,
    ST_EXP_ENTRY = 4'd5,
    ST_EXP_TEST  = 4'd6,
    ST_EXP_SLOT  = 4'd7,
    ST_EXP_DONE  = 4'd8,
    ST_FIN_TEST  = 4'd9,
    ST_FIN_SLOT  = 4'd10,
    ST_FINISH    = 4'd11
  } ustep_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_ADD,
    ACC_SUB,
    ACC_SUB_OR_ZERO
  } acc_op_e;

  typedef enum logic [1:0] {
    BEST_HOLD,
    BEST_UPDATE,
    BEST_CLEAR
  } best_op_e;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_CMP,
    EM_TAIL,
    EM_SLOT
  } emit_op_e;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_MODE_EXP,
    CND_ROW_END,
    CND_ACC_LT,
    CND_EXP_STOP,
    CND_FIN_STOP
  } cond_e;

  typedef struct packed {
    logic     take;
    acc_op_e  acc_op;
    best_op_e best_op;
    emit_op_e emit_op;
    logic     reps_inc;
    logic     fin;
    cond_e    cond;
    ustep_e   target;
  } uword_t;

  typedef struct packed {
    logic mode_exp;
    logic row_end;
    logic acc_ge;
    logic exp_run;
    logic fin_run;
  } cond_flags_t;

  typedef struct packed {
    logic             valid;
    logic [LVL_W-1:0] color;
    logic [IDX_W-1:0] index;
  } emit_t;

endpackage

`default_nettype wire

@@ src/rrrm_useq.sv @@
// Microcode sequencer of the row resampler: step counter, control ROM and jumps.
// Depends on rrrm_pkg.
`default_nettype none

module rrrm_useq import rrrm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        blocked_i,
  input  cond_flags_t cond_i,
  output uword_t      word_o,
  output logic        go_o,
  output ustep_e      step_o
);

  function automatic uword_t mw(logic take, acc_op_e acc, best_op_e best, emit_op_e em,
                                logic reps, logic fin, cond_e cnd, ustep_e tgt);
    uword_t w;
    w.take     = take;
    w.acc_op   = acc;
    w.best_op  = best;
    w.emit_op  = em;
    w.reps_inc = reps;
    w.fin      = fin;
    w.cond     = cnd;
    w.target   = tgt;
    return w;
  endfunction

  function automatic uword_t ucode_rom(ustep_e s);
    uword_t w;
    unique case (s)
      ST_FETCH:     w = mw(1'b1, ACC_HOLD, BEST_HOLD, EM_NONE, 1'b0, 1'b0,
                           CND_MODE_EXP, ST_EXP_ENTRY);
      ST_CMP_ACC:   w = mw(1'b0, ACC_ADD, BEST_UPDATE, EM_NONE, 1'b0, 1'b0,
                           CND_NEVER, ST_FETCH);
      ST_CMP_TEST:  w = mw(1'b0, ACC_HOLD, BEST_HOLD, EM_NONE, 1'b0, 1'b0,
                           CND_ACC_LT, ST_CMP_TAIL);
      ST_CMP_EMIT:  w = mw(1'b0, ACC_SUB, BEST_CLEAR, EM_CMP, 1'b0, 1'b0,
                           CND_ALWAYS, ST_CMP_TEST);
      ST_CMP_TAIL:  w = mw(1'b0, ACC_HOLD, BEST_HOLD, EM_TAIL, 1'b0, 1'b0,
                           CND_ALWAYS, ST_FINISH);
      ST_EXP_ENTRY: w = mw(1'b0, ACC_HOLD, BEST_HOLD, EM_NONE, 1'b0, 1'b0,
                           CND_ROW_END, ST_FIN_TEST);
      ST_EXP_TEST:  w = mw(1'b0, ACC_HOLD, BEST_HOLD, EM_NONE, 1'b0, 1'b0,
                           CND_EXP_STOP, ST_EXP_DONE);
      ST_EXP_SLOT:  w = mw(1'b0, ACC_ADD, BEST_HOLD, EM_SLOT, 1'b1, 1'b0,
                           CND_ALWAYS, ST_EXP_TEST);
      ST_EXP_DONE:  w = mw(1'b0, ACC_SUB_OR_ZERO, BEST_HOLD, EM_NONE, 1'b0, 1'b0,
                           CND_ALWAYS, ST_FINISH);
      ST_FIN_TEST:  w = mw(1'b0, ACC_HOLD, BEST_HOLD, EM_NONE, 1'b0, 1'b0,
                           CND_FIN_STOP, ST_FINISH);
      ST_FIN_SLOT:  w = mw(1'b0, ACC_HOLD, BEST_HOLD, EM_SLOT, 1'b1, 1'b0,
                           CND_ALWAYS, ST_FIN_TEST);
      ST_FINISH:    w = mw(1'b0, ACC_HOLD, BEST_HOLD, EM_NONE, 1'b0, 1'b1,
                           CND_ALWAYS, ST_FETCH);
      default:      w = mw(1'b0, ACC_HOLD, BEST_HOLD, EM_NONE, 1'b0, 1'b0,
                           CND_ALWAYS, ST_FETCH);
    endcase
    return w;
  endfunction

  ustep_e step_q, step_d;
  uword_t word;
  logic   jump;
  logic   needs_push;

  // Output block: decode the current control word and decide whether it runs.
  always_comb begin
    word       = ucode_rom(step_q);
    needs_push = (word.emit_op != EM_NONE) | word.fin;
    go_o       = (~word.take | in_valid_i) & ~(needs_push & blocked_i);
    word_o     = word;
    step_o     = step_q;
  end

  // Next-step block.
  always_comb begin
    unique case (word.cond)
      CND_NEVER:    jump = 1'b0;
      CND_ALWAYS:   jump = 1'b1;
      CND_MODE_EXP: jump = cond_i.mode_exp;
      CND_ROW_END:  jump = cond_i.row_end;
      CND_ACC_LT:   jump = ~cond_i.acc_ge;
      CND_EXP_STOP: jump = ~cond_i.exp_run;
      CND_FIN_STOP: jump = ~cond_i.fin_run;
      default:      jump = 1'b1;
    endcase
    step_d = step_q;
    if (go_o) begin
      step_d = jump ? word.target : ustep_e'(step_q + STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

@@ src/rrrm_dpath.sv @@
// Datapath of the row resampler: item latch, step accumulator, running maximum,
// pixel counter and repeat counter, all driven by the control word. Needs rrrm_pkg.
`default_nettype none

module rrrm_dpath import rrrm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  uword_t      word_i,
  input  logic        go_i,
  input  in_item_t    in_item_i,
  output cond_flags_t cond_o,
  output emit_t       emit_o
);

  logic [LVL_W-1:0]  level_q;
  logic              row_end_q;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [LVL_W-1:0]  best_level_q, best_level_d;
  logic [LVL_W-1:0]  best_mag_q, best_mag_d;
  logic [PTS_W-1:0]  pe_q, pe_d;
  logic              pending_q, pending_d;
  logic [REPS_W-1:0] reps_q, reps_d;

  logic              take;
  logic              acc_ge;
  logic              pe_lt_out;
  logic              slot_hit;
  logic [PTS_W-1:0]  slot_col;
  logic [LVL_W-1:0]  mag;
  logic              cand;
  logic [LVL_W-1:0]  em_level;
  logic [IDX_W-1:0]  em_index;

  assign take      = go_i & word_i.take;
  assign acc_ge    = acc_q >= ACC_ONE;
  assign pe_lt_out = pe_q < cfg_i.out_points;
  // Expand slots count down from column out_points; that first slot is dropped.
  assign slot_hit  = (pe_q != '0) && (pe_q <= cfg_i.out_points);
  assign slot_col  = cfg_i.out_points - pe_q;
  assign mag       = level_q[LVL_W-1] ? (~level_q + LVL_W'(1)) : level_q;

  always_comb begin
    cond_o.mode_exp = cfg_i.out_points > cfg_i.in_points;
    cond_o.row_end  = row_end_q;
    cond_o.acc_ge   = acc_ge;
    cond_o.exp_run  = ~acc_ge && (reps_q < REPS_W'(MAX_EXPAND));
    cond_o.fin_run  = (pe_q <= cfg_i.out_points) && (reps_q < REPS_W'(MAX_EXPAND + 1));
  end

  always_comb begin
    unique case (word_i.emit_op)
      EM_NONE: begin
        cand     = 1'b0;
        em_level = best_level_q;
        em_index = pe_q[IDX_W-1:0];
      end
      EM_CMP: begin
        cand     = pe_lt_out;
        em_level = best_level_q;
        em_index = pe_q[IDX_W-1:0];
      end
      EM_TAIL: begin
        cand     = row_end_q & pending_q & pe_lt_out;
        em_level = best_level_q;
        em_index = pe_q[IDX_W-1:0];
      end
      EM_SLOT: begin
        cand     = slot_hit;
        em_level = level_q;
        em_index = slot_col[IDX_W-1:0];
      end
      default: begin
        cand     = 1'b0;
        em_level = level_q;
        em_index = pe_q[IDX_W-1:0];
      end
    endcase
    emit_o.valid = go_i & cand;
    emit_o.color = em_level + cfg_i.color_ofs;
    emit_o.index = em_index;
  end

  always_comb begin
    acc_d        = acc_q;
    best_level_d = best_level_q;
    best_mag_d   = best_mag_q;
    pe_d         = pe_q;
    pending_d    = pending_q;
    reps_d       = reps_q;
    if (go_i) begin
      unique case (word_i.acc_op)
        ACC_HOLD:        acc_d = acc_q;
        ACC_ADD:         acc_d = acc_q + ACC_W'(cfg_i.step_inc);
        ACC_SUB:         acc_d = acc_q - ACC_ONE;
        ACC_SUB_OR_ZERO: acc_d = acc_ge ? (acc_q - ACC_ONE) : '0;
        default:         acc_d = acc_q;
      endcase
      unique case (word_i.best_op)
        BEST_UPDATE: begin
          // Strictly greater, so the earliest of equal magnitudes is kept.
          if (mag > best_mag_q) begin
            best_level_d = level_q;
            best_mag_d   = mag;
          end
          pending_d = 1'b1;
        end
        BEST_CLEAR: begin
          best_level_d = '0;
          best_mag_d   = '0;
          pending_d    = 1'b0;
        end
        default: begin
          best_level_d = best_level_q;
        end
      endcase
      unique case (word_i.emit_op)
        EM_CMP, EM_TAIL: begin
          if (cand) begin
            pe_d = pe_q + PTS_W'(1);
          end
        end
        EM_SLOT: begin
          if (pe_q != PTS_W'(SLOT_LIMIT)) begin
            pe_d = pe_q + PTS_W'(1);
          end
        end
        default: begin
          pe_d = pe_q;
        end
      endcase
      if (take) begin
        reps_d = '0;
      end else if (word_i.reps_inc) begin
        reps_d = reps_q + REPS_W'(1);
      end
      if (word_i.fin && row_end_q) begin
        acc_d        = '0;
        best_level_d = '0;
        best_mag_d   = '0;
        pe_d         = '0;
        pending_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      best_level_q <= '0;
      best_mag_q   <= '0;
      pe_q         <= '0;
      pending_q    <= 1'b0;
      reps_q       <= '0;
    end else begin
      acc_q        <= acc_d;
      best_level_q <= best_level_d;
      best_mag_q   <= best_mag_d;
      pe_q         <= pe_d;
      pending_q    <= pending_d;
      reps_q       <= reps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      level_q   <= in_item_i.level;
      row_end_q <= in_item_i.row_end;
    end
  end

endmodule

`default_nettype wire

@@ src/rrrm_obuf.sv @@
// Result buffer of the row resampler: a one-entry hold stage that learns which
// pixel is the last of its request, followed by the output register. Needs rrrm_pkg.
`default_nettype none

module rrrm_obuf import rrrm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  emit_t     emit_i,
  input  logic      fin_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  output logic      blocked_o,
  output logic      hold_valid_o
);

  logic             hold_valid_q, hold_valid_d;
  logic [LVL_W-1:0] hold_color_q;
  logic [IDX_W-1:0] hold_index_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q;
  out_item_t        push_item;
  logic             push;

  // A held pixel moves on when a newer one arrives or when the request ends;
  // only in the latter case is it the last one.
  assign push      = (emit_i.valid | fin_i) & hold_valid_q;
  assign blocked_o = hold_valid_q & out_valid_q & out_stall_i;

  always_comb begin
    push_item.pixel_color = hold_color_q;
    push_item.pixel_index = hold_index_q;
    push_item.last_of_run = fin_i;
    out_valid_d           = push | (out_valid_q & out_stall_i);
    hold_valid_d          = hold_valid_q;
    if (emit_i.valid) begin
      hold_valid_d = 1'b1;
    end else if (fin_i) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.valid) begin
      hold_color_q <= emit_i.color;
      hold_index_q <= emit_i.index;
    end
    if (push) begin
      out_q <= push_item;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_item_o   = out_q;
  assign hold_valid_o = hold_valid_q;

endmodule

`default_nettype wire

@@ src/raster_row_resample_max_magnitude.sv @@
// Row resampler for a colour raster, microcoded: top level with configuration
// registers. Depends on rrrm_pkg, rrrm_useq, rrrm_dpath, rrrm_obuf and assert_macros.svh.
//
// Usage: write in_points, out_points, step_increment and color_offset through the
// cfg port while the block is idle, then stream one row of signed levels on the
// input channel with row_end set on the last one. When out_points <= in_points
// each pixel carries the largest-magnitude level it covers; otherwise inputs
// arrive right to left and are repeated. Each input request yields zero or more
// pixel requests on the output channel; last_of_run marks the final one.
// Sequencing: the sequencer handles one request at a time. A compress request
// steps through fetch, accumulate, test, tail and finish, plus emit and test for
// each whole unit the accumulator counts off; an expand request through fetch,
// entry, test, done and finish, plus slot and test per slot (at most 63); the last
// request of an expand row likewise without done (at most 64). Each pixel leaves
// the hold stage when the next pixel or the end of the request arrives, so the last
// pixel appears in the cycle after the program finishes. A stalled output holds
// its request; the sequencer freezes at a step that may move a pixel while the
// hold stage and output register are full. Reset clears all row state and loads
// default registers; the block is ready in the next cycle.
`default_nettype none
`include "assert_macros.svh"

module raster_row_resample_max_magnitude import rrrm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [INC_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o
);

  cfg_t        cfg_q, cfg_d;
  uword_t      word;
  logic        go;
  ustep_e      step;
  cond_flags_t cond;
  emit_t       emit;
  logic        blocked;
  logic        hold_valid;
  logic        out_busy;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_IN_POINTS:  cfg_d.in_points  = cfg_data_i[PTS_W-1:0];
        CFG_OUT_POINTS: cfg_d.out_points = cfg_data_i[PTS_W-1:0];
        CFG_STEP_INC:   cfg_d.step_inc   = cfg_data_i;
        CFG_COLOR_OFS:  cfg_d.color_ofs  = cfg_data_i[LVL_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_points  <= PTS_W'(2);
      cfg_q.out_points <= PTS_W'(1);
      cfg_q.step_inc   <= INC_W'(STEP_ONE);
      cfg_q.color_ofs  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rrrm_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .blocked_i  (blocked),
    .cond_i     (cond),
    .word_o     (word),
    .go_o       (go),
    .step_o     (step)
  );

  rrrm_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .word_i    (word),
    .go_i      (go),
    .in_item_i (in_item_i),
    .cond_o    (cond),
    .emit_o    (emit)
  );

  rrrm_obuf u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_i       (emit),
    .fin_i        (go & word.fin),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_item_o   (out_item_o),
    .blocked_o    (blocked),
    .hold_valid_o (hold_valid)
  );

  assign in_stall_o = ~word.take;
  assign out_busy   = out_valid_o & out_stall_i;

  `ASSERT_NEXT(a_take_leaves_fetch, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `ASSERT_IMPLIES(a_hold_empty_at_fetch, clk_i, rst_ni, step == ST_FETCH, !hold_valid)
  `ASSERT_IMPLIES(a_no_push_into_busy_out, clk_i, rst_ni, emit.valid && hold_valid, !out_busy)

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking bench for raster_row_resample_max_magnitude: compress and expand rows,
// random request gaps and output stalls, pixels checked against a behavioral predictor.
// Depends on rrrm_pkg and the RTL of the row resampler.
`timescale 1ns / 1ps

module tb_top;
  import rrrm_pkg::*;

  localparam int DRAIN_CYCLES = 160;
  localparam int LONG_HOLD    = 600;
  localparam int PIXEL_CAP    = 64;
  localparam int ITEM_TARGET  = 310;

  typedef struct {
    bit          is_cfg;
    cfg_idx_e    sel;
    int unsigned value;
    logic [7:0]  level;
    bit          row_end;
    int          typed_n;
    out_item_t   typed_px;
  } plan_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  cfg_idx_e  cfg_index_i = CFG_IN_POINTS;
  logic [INC_W-1:0] cfg_data_i = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  raster_row_resample_max_magnitude dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow registers and row state of the predictor.
  logic [PTS_W-1:0] cf_in_pts  = 13'd2;
  logic [PTS_W-1:0] cf_out_pts = 13'd1;
  logic [INC_W-1:0] cf_inc     = 19'd262144;
  logic [LVL_W-1:0] cf_ofs     = 8'd0;
  logic [ACC_W-1:0] acc        = '0;
  logic [LVL_W-1:0] best_lvl   = '0;
  logic [8:0]       best_mag   = '0;
  logic [PTS_W-1:0] emitted    = '0;
  bit               max_pending = 1'b0;

  out_item_t calc_px[$];
  out_item_t pending_pixels[$];
  plan_row_t plan[$];

  int        tag_n  = -1;
  out_item_t tag_px = '0;
  int        fail_cnt  = 0;
  int        quiet_cnt = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        hold_reqs = 0;
  int        sent = 0;

  function automatic void add_pixel(logic [7:0] lvl, int unsigned col);
    out_item_t px;
    px.pixel_color = lvl + cf_ofs;
    px.pixel_index = col[IDX_W-1:0];
    px.last_of_run = 1'b0;
    calc_px.push_back(px);
  endfunction

  // Expand mode consumes one slot per call, counting down from column out_points.
  function automatic void expand_slot(logic [7:0] lvl);
    int pos;
    pos = int'(cf_out_pts) - int'(emitted);
    if (pos >= 0 && pos < int'(cf_out_pts)) add_pixel(lvl, pos);
    if (emitted < SLOT_LIMIT) emitted++;
  endfunction

  function automatic void predict_pixels(in_item_t req);
    logic [7:0] raw;
    logic [8:0] mag;
    int         reps;
    out_item_t  tail;
    raw = req.level;
    calc_px.delete();
    if (cf_out_pts <= cf_in_pts) begin
      mag = raw[7] ? 9'd256 - raw : {1'b0, raw};
      acc += cf_inc;
      if (mag > best_mag) begin
        best_lvl = raw;
        best_mag = mag;
      end
      max_pending = 1'b1;
      while (acc >= STEP_ONE) begin
        if (emitted < cf_out_pts && calc_px.size() < PIXEL_CAP) begin
          add_pixel(best_lvl, emitted);
          emitted++;
        end
        acc -= STEP_ONE;
        best_lvl = '0;
        best_mag = '0;
        max_pending = 1'b0;
      end
      if (req.row_end && max_pending && emitted < cf_out_pts && calc_px.size() < PIXEL_CAP) begin
        add_pixel(best_lvl, emitted);
        emitted++;
      end
    end else if (!req.row_end) begin
      reps = 0;
      while (acc < STEP_ONE && reps < MAX_EXPAND) begin
        expand_slot(raw);
        acc += cf_inc;
        reps++;
      end
      if (acc >= STEP_ONE) acc -= STEP_ONE;
      else acc = '0;
    end else begin
      reps = 0;
      while (emitted <= cf_out_pts && reps < MAX_EXPAND + 1) begin
        expand_slot(raw);
        reps++;
      end
    end
    if (req.row_end) begin
      acc = '0;
      best_lvl = '0;
      best_mag = '0;
      emitted = '0;
      max_pending = 1'b0;
    end
    if (calc_px.size() > 0) begin
      tail = calc_px.pop_back();
      tail.last_of_run = 1'b1;
      calc_px.push_back(tail);
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni) begin
      quiet_cnt++;
      if (in_valid_i && !in_stall_o) begin
        quiet_cnt = 0;
        predict_pixels(in_item_i);
        if (tag_n < 0) begin
          foreach (calc_px[k]) pending_pixels.push_back(calc_px[k]);
        end else if (tag_n > 0) begin
          pending_pixels.push_back(tag_px);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        quiet_cnt = 0;
        if (pending_pixels.size() == 0) begin
          $error("pixel request with none expected: color %0d index %0d",
                 out_item_o.pixel_color, out_item_o.pixel_index);
          fail_cnt++;
        end else begin
          want = pending_pixels.pop_front();
          if (out_item_o.pixel_color !== want.pixel_color) begin
            $error("pixel_color: expected %0d, got %0d", want.pixel_color, out_item_o.pixel_color);
            fail_cnt++;
          end
          if (out_item_o.pixel_index !== want.pixel_index) begin
            $error("pixel_index: expected %0d, got %0d", want.pixel_index, out_item_o.pixel_index);
            fail_cnt++;
          end
          if (out_item_o.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run, out_item_o.last_of_run);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Output stalls; a long hold is requested by bumping hold_reqs.
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    #6_000_000;
    $display("simulation failed");
    $finish;
  end

  // All tasks below start and end right after a falling edge.
  task automatic send_request(logic [7:0] lvl, bit last, int n, out_item_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_item_i.level   <= lvl;
    in_item_i.row_end <= last;
    tag_n             <= n;
    tag_px            <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_pixels.size() != 0 || quiet_cnt < DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e sel, int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= val[INC_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (sel)
      CFG_IN_POINTS:  cf_in_pts  = val[PTS_W-1:0];
      CFG_OUT_POINTS: cf_out_pts = val[PTS_W-1:0];
      CFG_STEP_INC:   cf_inc     = val[INC_W-1:0];
      CFG_COLOR_OFS:  cf_ofs     = val[LVL_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic run_row(int unsigned n_in, int unsigned n_out, int unsigned inc,
                         int unsigned ofs, int items, bit with_end);
    logic [7:0] corner_lvls[4];
    logic [7:0] lvl;
    corner_lvls = '{8'h80, 8'h7f, 8'h00, 8'hff};
    wait_idle();
    write_reg(CFG_IN_POINTS, n_in);
    write_reg(CFG_OUT_POINTS, n_out);
    write_reg(CFG_STEP_INC, inc);
    write_reg(CFG_COLOR_OFS, ofs);
    for (int k = 0; k < items; k++) begin
      lvl = ($urandom_range(4) == 0) ? corner_lvls[$urandom_range(3)] : 8'($urandom);
      send_request(lvl, with_end && (k == items - 1), -1, '0);
    end
    sent += items;
  endtask

  function automatic void plan_cfg(cfg_idx_e sel, int unsigned val);
    plan_row_t r;
    r.is_cfg   = 1'b1;
    r.sel      = sel;
    r.value    = val;
    r.level    = '0;
    r.row_end  = 1'b0;
    r.typed_n  = -1;
    r.typed_px = '0;
    plan.push_back(r);
  endfunction

  function automatic void plan_req(logic [7:0] lvl, bit last, int n = -1,
                                   logic [7:0] color = '0, logic [11:0] index = '0);
    plan_row_t r;
    r.is_cfg   = 1'b0;
    r.sel      = CFG_IN_POINTS;
    r.value    = 0;
    r.level    = lvl;
    r.row_end  = last;
    r.typed_n  = n;
    r.typed_px = '{pixel_color: color, pixel_index: index, last_of_run: 1'b1};
    plan.push_back(r);
  endfunction

  initial begin : stimulus
    int unsigned n_in, n_out, inc, ofs;
    int          kind, items, lim;
    bit          prev_cfg;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Default registers after reset: one pixel per input, the second falls off the row.
    plan_req(8'h80, 1'b0, 1, 8'h80, 12'd0);
    plan_req(8'h7f, 1'b1, 0);
    // Half-unit compress with wrap of the offset; a tie keeps the earlier level.
    plan_cfg(CFG_IN_POINTS, 8);
    plan_cfg(CFG_OUT_POINTS, 4);
    plan_cfg(CFG_STEP_INC, 131072);
    plan_cfg(CFG_COLOR_OFS, 255);
    plan_req(8'd5, 1'b0);
    plan_req(-8'sd5, 1'b0);
    plan_req(8'h00, 1'b0);
    plan_req(8'hff, 1'b0);
    plan_req(8'h7f, 1'b0);
    plan_req(8'h80, 1'b1);
    // Oversized increment: up to two pixels per input, then the row runs full.
    plan_cfg(CFG_IN_POINTS, 4);
    plan_cfg(CFG_STEP_INC, 524287);
    plan_cfg(CFG_COLOR_OFS, 0);
    plan_req(8'd100, 1'b0);
    plan_req(-8'sd3, 1'b0);
    plan_req(8'd7, 1'b1);
    // Zero increment never advances; only the pending maximum comes out at row end.
    plan_cfg(CFG_OUT_POINTS, 2);
    plan_cfg(CFG_STEP_INC, 0);
    plan_cfg(CFG_COLOR_OFS, 16);
    plan_req(-8'sd9, 1'b0);
    plan_req(8'd20, 1'b0);
    plan_req(-8'sd30, 1'b1);
    // Expand: the first slot is dropped and the last input fills down to column zero.
    plan_cfg(CFG_IN_POINTS, 2);
    plan_cfg(CFG_OUT_POINTS, 8);
    plan_cfg(CFG_STEP_INC, 65536);
    plan_cfg(CFG_COLOR_OFS, 1);
    plan_req(8'd10, 1'b0);
    plan_req(8'h80, 1'b1);
    // Tiny increment hits the repeat cap on both inputs.
    plan_cfg(CFG_OUT_POINTS, 200);
    plan_cfg(CFG_STEP_INC, 1);
    plan_req(8'd33, 1'b0);
    plan_req(-8'sd77, 1'b1);
    // Widest row in both modes.
    plan_cfg(CFG_OUT_POINTS, 4096);
    plan_cfg(CFG_STEP_INC, 128);
    plan_cfg(CFG_COLOR_OFS, 255);
    plan_req(8'h7f, 1'b0);
    plan_req(8'h80, 1'b1);
    plan_cfg(CFG_IN_POINTS, 4096);
    plan_cfg(CFG_STEP_INC, 262144);
    plan_cfg(CFG_COLOR_OFS, 128);
    plan_req(8'h80, 1'b0);
    plan_req(8'h7f, 1'b0);
    plan_req(8'h00, 1'b1);

    prev_cfg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!prev_cfg) wait_idle();
        write_reg(plan[i].sel, plan[i].value);
      end else begin
        send_request(plan[i].level, plan[i].row_end, plan[i].typed_n, plan[i].typed_px);
        sent++;
      end
      prev_cfg = plan[i].is_cfg;
    end

    // Output held off while an expand row keeps arriving, so the input backs up.
    wait_idle();
    hold_reqs++;
    run_row(4, 64, 16384, 3, 4, 1'b1);

    while (sent < ITEM_TARGET) begin
      if (sent < 90) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end else if (sent < 160) begin
        send_idle_pct = 49;
        stall_pct     = 0;
      end else if (sent < 240) begin
        send_idle_pct = 0;
        stall_pct     = 49;
      end else begin
        send_idle_pct = 14;
        stall_pct     = 14;
      end
      kind = $urandom_range(99);
      ofs  = ($urandom_range(3) == 0) ? 255 * $urandom_range(1) : $urandom_range(255);
      if (kind < 45) begin
        n_in  = $urandom_range(24, 2);
        n_out = $urandom_range(n_in, 1);
        inc   = (STEP_ONE * n_out) / n_in;
        items = ($urandom_range(6) == 0) ? $urandom_range(n_in + 3, 1) : n_in;
        run_row(n_in, n_out, inc, ofs, items, $urandom_range(9) != 0);
      end else if (kind < 80) begin
        n_out = $urandom_range(48, 3);
        lim   = (n_out - 1 < 12) ? n_out - 1 : 12;
        n_in  = $urandom_range(lim, 2);
        inc   = (STEP_ONE * n_in) / n_out;
        items = ($urandom_range(6) == 0) ? $urandom_range(n_in + 3, 1) : n_in;
        run_row(n_in, n_out, inc, ofs, items, $urandom_range(9) != 0);
      end else if (kind < 88) begin
        case ($urandom_range(2))
          0:       run_row(2, 4096, 128, ofs, 2, 1'b1);
          1:       run_row(4096, 4096, 262144, ofs, $urandom_range(10, 4), 1'b1);
          default: run_row(4096, 1, 64, ofs, 6, 1'b1);
        endcase
      end else begin
        // Registers anywhere in their field widths, rows of one to ten inputs.
        run_row($urandom_range(8191), $urandom_range(8191), $urandom_range(524287), ofs,
                $urandom_range(10, 1), $urandom_range(1));
      end
    end

    send_idle_pct = 0;
    wait_idle();
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
